// ===== src/rpc_pkg.sv =====
// Shared constants and types for the RGB565 pixel compositor.
package rpc_pkg;

	localparam int unsigned SCREEN_WIDTH  = 240;
	localparam int unsigned SCREEN_HEIGHT = 240;
	localparam int unsigned FRAME_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int unsigned FRAME_AW      = $clog2(FRAME_DEPTH);

	// Coordinates that pass the range checks fit in this many bits
	localparam int unsigned COORD_W = 11;

	localparam int unsigned ALPHA_ONE = 256;

	localparam logic [15:0] MASK_RB = 16'hF81F;
	localparam logic [15:0] MASK_G  = 16'h07E0;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [1:0] REG_CLIP_TOP    = 2'd0;
	localparam logic [1:0] REG_CLIP_BOTTOM = 2'd1;
	localparam logic [1:0] REG_INK_ENABLE  = 2'd2;

	// Classified pixel, front to back
	typedef struct packed {
		logic                op;
		logic                ok;
		logic [FRAME_AW-1:0] idx;
		logic [7:0]          red;
		logic [7:0]          green;
		logic [7:0]          blue;
		logic [8:0]          alpha;
	} rpc_item_t;

endpackage

// ===== src/rgb565_pixel_compositor.sv =====
// Top level of the RGB565 pixel compositor: config registers and front/queue/back wiring.
//
//  channel   handshake        accepted when        payload
//  pixels    push / full      push & !full         operation, pixel_x/y, colour, alphas
//  results   empty / pop      pop & !empty         written, pixel_index, pixel_value
//  config    cfg_we           cfg_we               cfg_index, cfg_data
//
// The front takes one pixel a cycle unless full and registers it before the queue write.
// The back retires skipped or opaque pixels in ST_ISSUE, blended pixels in ST_MERGE:
// the frame store read is registered before the blend and write-back.
// After reset the ink map is cleared one entry a cycle, all SCREEN_WIDTH * SCREEN_HEIGHT
// (57600) entries, with full held high; config writes are taken throughout.
// A result waiting in the output register stalls only the back; the queue keeps filling.
module rgb565_pixel_compositor import rpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic signed [11:0] pixel_x,
	input  logic signed [11:0] pixel_y,
	input  logic [7:0]         color_red,
	input  logic [7:0]         color_green,
	input  logic [7:0]         color_blue,
	input  logic [8:0]         color_alpha,
	input  logic [8:0]         coverage_alpha,
	input  logic               pop,
	output logic               empty,
	output logic               written,
	output logic [15:0]        pixel_index,
	output logic [15:0]        pixel_value,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic [7:0] clip_top_q;
	logic [7:0] clip_bottom_q;
	logic       ink_enable_q;

	logic       clr_busy;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	rpc_item_t  front_item;
	rpc_item_t  head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_top_q    <= 8'd0;
			clip_bottom_q <= 8'd240;
			ink_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIP_TOP:    clip_top_q    <= cfg_data;
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data;
				REG_INK_ENABLE:  ink_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rpc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.color_red      (color_red),
		.color_green    (color_green),
		.color_blue     (color_blue),
		.color_alpha    (color_alpha),
		.coverage_alpha (coverage_alpha),
		.clip_top       (clip_top_q),
		.clip_bottom    (clip_bottom_q),
		.clr_busy       (clr_busy),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (front_item)
	);

	rpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (front_item),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_item (head_item),
		.q_empty (q_empty)
	);

	rpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.ink_enable  (ink_enable_q),
		.clr_busy    (clr_busy),
		.pop         (pop),
		.empty       (empty),
		.written     (written),
		.pixel_index (pixel_index),
		.pixel_value (pixel_value)
	);

endmodule

// ===== src/rpc_front.sv =====
// Front end: accepts pixels, works out alpha, clips and computes the frame index.
module rpc_front import rpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              operation,
	input  logic signed [11:0] pixel_x,
	input  logic signed [11:0] pixel_y,
	input  logic [7:0]        color_red,
	input  logic [7:0]        color_green,
	input  logic [7:0]        color_blue,
	input  logic [8:0]        color_alpha,
	input  logic [8:0]        coverage_alpha,
	input  logic [7:0]        clip_top,
	input  logic [7:0]        clip_bottom,
	input  logic              clr_busy,
	input  logic              q_full,
	output logic              q_push,
	output rpc_item_t         q_item
);

	logic               accept;
	logic [17:0]        alpha_prod;
	logic [9:0]         alpha_raw;
	logic [8:0]         alpha_clamped;
	logic               x_ok;
	logic               y_ok;
	logic               clip_ok;
	logic [COORD_W-1:0] x_u;
	logic [COORD_W-1:0] y_u;
	logic [23:0]        idx_full;

	logic               valid_s1;
	logic               op_s1;
	logic               ok_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [7:0]         red_s1;
	logic [7:0]         green_s1;
	logic [7:0]         blue_s1;
	logic [8:0]         alpha_s1;

	assign full   = clr_busy | (valid_s1 & q_full);
	assign accept = push & ~full;
	assign q_push = valid_s1 & ~q_full;

	always_comb begin
		alpha_prod = 18'(coverage_alpha) * 18'(color_alpha);
		alpha_raw  = operation ? {1'b0, coverage_alpha} : alpha_prod[17:8];
		alpha_clamped = (alpha_raw > 10'(ALPHA_ONE)) ? 9'(ALPHA_ONE) : alpha_raw[8:0];
		x_u  = pixel_x[COORD_W-1:0];
		y_u  = pixel_y[COORD_W-1:0];
		x_ok = ~pixel_x[11] && ({1'b0, x_u} < 12'(SCREEN_WIDTH));
		y_ok = ~pixel_y[11] && ({1'b0, y_u} < 12'(SCREEN_HEIGHT));
		clip_ok = (y_u >= COORD_W'(clip_top)) && (y_u < COORD_W'(clip_bottom));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			ok_s1    <= x_ok & y_ok & clip_ok & (alpha_raw != 10'd0);
			x_s1     <= x_u;
			y_s1     <= y_u;
			red_s1   <= color_red;
			green_s1 <= color_green;
			blue_s1  <= color_blue;
			alpha_s1 <= alpha_clamped;
		end
	end

	always_comb begin
		idx_full     = 24'(y_s1) * 24'(SCREEN_WIDTH) + 24'(x_s1);
		q_item.op    = op_s1;
		q_item.ok    = ok_s1;
		q_item.idx   = FRAME_AW'(idx_full);
		q_item.red   = red_s1;
		q_item.green = green_s1;
		q_item.blue  = blue_s1;
		q_item.alpha = alpha_s1;
	end

endmodule

// ===== src/rpc_queue.sv =====
// Short queue of classified pixels between front and back.
module rpc_queue import rpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  rpc_item_t wr_item,
	output logic      q_full,
	input  logic      rd_en,
	output rpc_item_t rd_item,
	output logic      q_empty
);

	rpc_item_t        slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	assign q_full  = (count_q == (QAW+1)'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== src/rpc_back.sv =====
// Back end: frame store read-modify-write, ink map and the result register.
module rpc_back import rpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  rpc_item_t   q_item,
	output logic        q_pop,
	input  logic        ink_enable,
	output logic        clr_busy,
	input  logic        pop,
	output logic        empty,
	output logic        written,
	output logic [15:0] pixel_index,
	output logic [15:0] pixel_value
);

	typedef enum logic {ST_ISSUE, ST_MERGE} state_t;

	state_t              state_q;
	logic [15:0]         frame_mem [FRAME_DEPTH];
	logic                ink_mem [FRAME_DEPTH];
	logic [15:0]         rd_data_q;
	logic                clr_busy_q;
	logic [FRAME_AW-1:0] clr_addr_q;
	logic                res_valid_q;
	logic                written_q;
	logic [15:0]         index_q;
	logic [15:0]         value_q;

	logic        opaque;
	logic        slot_free;
	logic        direct;
	logic        rd_en;
	logic        finish;
	logic        wr_en;
	logic [15:0] src565;
	logic [15:0] blend_val;
	logic [15:0] new_val;

	function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic logic [8:0] inv_alpha(input logic [8:0] a);
		return 9'(10'(ALPHA_ONE) - {1'b0, a});
	endfunction

	function automatic logic [15:0] lane_blend(input logic [15:0] dst, input logic [15:0] src,
			input logic [8:0] a);
		logic [25:0] rb;
		logic [25:0] gg;
		rb = 26'(src & MASK_RB) * 26'(a) + 26'(dst & MASK_RB) * 26'(inv_alpha(a));
		gg = 26'(src & MASK_G) * 26'(a) + 26'(dst & MASK_G) * 26'(inv_alpha(a));
		return (rb[23:8] & MASK_RB) | (gg[23:8] & MASK_G);
	endfunction

	function automatic logic [7:0] chan_blend(input logic [7:0] c, input logic [7:0] d,
			input logic [8:0] a);
		logic [16:0] s;
		s = 17'(c) * 17'(a) + 17'(d) * 17'(inv_alpha(a));
		return s[15:8];
	endfunction

	// Expand the stored pixel to eight bits a channel by replicating its high bits
	function automatic logic [15:0] replicated_blend(input logic [15:0] dst,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [8:0] a);
		logic [7:0] dr;
		logic [7:0] dg;
		logic [7:0] db;
		dr = {dst[15:11], dst[15:13]};
		dg = {dst[10:5], dst[10:9]};
		db = {dst[4:0], dst[4:2]};
		return to565(chan_blend(r, dr, a), chan_blend(g, dg, a), chan_blend(b, db, a));
	endfunction

	always_comb begin
		opaque    = (q_item.alpha == 9'(ALPHA_ONE));
		slot_free = ~res_valid_q | pop;
		direct    = (state_q == ST_ISSUE) && !q_empty && (!q_item.ok || opaque);
		rd_en     = (state_q == ST_ISSUE) && !q_empty && q_item.ok && !opaque;
		finish    = slot_free && (direct || (state_q == ST_MERGE));
		wr_en     = finish && q_item.ok;
		q_pop     = finish;
		src565    = to565(q_item.red, q_item.green, q_item.blue);
		blend_val = q_item.op
			? replicated_blend(rd_data_q, q_item.red, q_item.green, q_item.blue, q_item.alpha)
			: lane_blend(rd_data_q, src565, q_item.alpha);
		new_val   = (state_q == ST_MERGE) ? blend_val : src565;
	end

	assign empty       = ~res_valid_q;
	assign written     = written_q;
	assign pixel_index = index_q;
	assign pixel_value = value_q;
	assign clr_busy    = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ISSUE;
			res_valid_q <= 1'b0;
			written_q   <= 1'b0;
			index_q     <= '0;
			value_q     <= '0;
		end else begin
			unique case (state_q)
				ST_ISSUE: begin
					if (rd_en) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (slot_free) begin
						state_q <= ST_ISSUE;
					end
				end
				default: state_q <= ST_ISSUE;
			endcase
			if (finish) begin
				res_valid_q <= 1'b1;
				written_q   <= q_item.ok;
				index_q     <= q_item.ok ? 16'(q_item.idx) : 16'd0;
				value_q     <= q_item.ok ? new_val : 16'd0;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Sweep the ink map clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == FRAME_AW'(FRAME_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[q_item.idx] <= new_val;
		end
		if (rd_en) begin
			rd_data_q <= frame_mem[q_item.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			ink_mem[clr_addr_q] <= 1'b0;
		end else if (wr_en && ink_enable) begin
			ink_mem[q_item.idx] <= 1'b1;
		end
	end

endmodule
